// ----- rtl/core/s7s_pkg.sv -----
`default_nettype none

package s7s_pkg;

	// Width of the value shown on the display
	localparam int VALUE_W = 16;

	// Divide by ten: q = (v * 52429) >> 19 is exact for every 16-bit v
	localparam int DIV10_SHIFT = 19;
	localparam logic [16:0] DIV10_MUL = 17'd52429;
	localparam int DIV10_PROD_W = VALUE_W + 17;

	// Converter filter constants
	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] REPEAT_LIMIT = 5'd30;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
	localparam int NEAR_BAND = 4;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIM_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHT_DIGIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADC_ENABLE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOT_POSITION = 2'd3;

	typedef struct packed {
		logic dim_enable;
		logic [2:0] bright_digit;
		logic adc_enable;
		logic [2:0] dot_position;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dim_enable: 1'b0,
		bright_digit: 3'd2,
		adc_enable: 1'b1,
		dot_position: 3'd4
	};

	// Active-high segment pattern a..g for one decimal digit
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'd0: pat = 8'h3F;
			4'd1: pat = 8'h06;
			4'd2: pat = 8'h5B;
			4'd3: pat = 8'h4F;
			4'd4: pat = 8'h66;
			4'd5: pat = 8'h6D;
			4'd6: pat = 8'h7D;
			4'd7: pat = 8'h27;
			4'd8: pat = 8'h7F;
			4'd9: pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/seven_segment_scan_with_adc_filter.sv -----
// Seven-segment scan driver with a stabilized converter reading.
// A transaction loads the input register on acceptance and moves into the
// result register once that is free. Throughput: one slot per cycle unless
// out_stall holds the result; the result register frees up as it is taken.
// Reset clears the slot counter, filter state and valid flags and loads the
// register defaults (no dimming, bright digit 2, converter on, dot on digit 4).
`default_nettype none

module seven_segment_scan_with_adc_filter import s7s_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	parameter int SAMPLE_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [VALUE_W-1:0] show_value,
	input wire logic [SAMPLE_BITS-1:0] adc_sample,
	output logic out_valid,
	input wire logic out_stall,
	output logic [DIGIT_COUNT-1:0] digit_select,
	output logic [7:0] segments,
	output logic short_on,
	output logic [SAMPLE_BITS-1:0] stable_reading,
	output logic scan_end
);

	localparam int SLOT_W = $clog2(DIGIT_COUNT);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGIT_COUNT - 1);

	cfg_t cfg_q;
	logic [SLOT_W-1:0] slot_q;
	logic [VALUE_W-1:0] remaining_q;

	logic valid_s1;
	logic [VALUE_W-1:0] show_value_s1;
	logic [SAMPLE_BITS-1:0] adc_sample_s1;

	logic valid_s2;
	logic [DIGIT_COUNT-1:0] digit_select_s2;
	logic [7:0] segments_s2;
	logic short_on_s2;
	logic [SAMPLE_BITS-1:0] stable_reading_s2;
	logic scan_end_s2;

	logic s2_free;
	logic s1_free;
	logic s2_load;
	logic first_slot;
	logic last_slot;

	logic [DIGIT_COUNT-1:0] dig_select;
	logic [7:0] dig_segments;
	logic dig_short;
	logic [VALUE_W-1:0] remaining_next;
	logic [SAMPLE_BITS-1:0] filt_cur;
	logic [SAMPLE_BITS-1:0] filt_next;

	// Handshake: each register moves when the one after it frees up
	assign s2_free = !valid_s2 || !out_stall;
	assign s1_free = !valid_s1 || s2_free;
	assign s2_load = valid_s1 && s2_free;
	assign in_stall = !s1_free;

	assign first_slot = (slot_q == '0);
	assign last_slot = (slot_q == LAST_SLOT);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DIM_ENABLE: cfg_q.dim_enable <= cfg_data[0];
				CFG_BRIGHT_DIGIT: cfg_q.bright_digit <= cfg_data;
				CFG_ADC_ENABLE: cfg_q.adc_enable <= cfg_data[0];
				CFG_DOT_POSITION: cfg_q.dot_position <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			show_value_s1 <= show_value;
			adc_sample_s1 <= adc_sample;
		end
	end

	s7s_digit #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_digit (
		.slot(slot_q),
		.show_value(show_value_s1),
		.remaining(remaining_q),
		.cfg(cfg_q),
		.digit_select(dig_select),
		.segments(dig_segments),
		.short_on(dig_short),
		.remaining_next(remaining_next)
	);

	s7s_filter #(
		.DIGIT_COUNT(DIGIT_COUNT),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_filter (
		.clk(clk),
		.arst_n(arst_n),
		.advance(s2_load),
		.first_slot(first_slot),
		.last_slot(last_slot),
		.adc_enable(cfg_q.adc_enable),
		.sample(adc_sample_s1),
		.filtered_cur(filt_cur),
		.filtered_next(filt_next)
	);

	// Advance the slot counter and the remaining value per processed slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			remaining_q <= '0;
		end else if (s2_load) begin
			slot_q <= last_slot ? '0 : slot_q + 1'b1;
			remaining_q <= remaining_next;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			digit_select_s2 <= dig_select;
			segments_s2 <= dig_segments;
			short_on_s2 <= dig_short;
			stable_reading_s2 <= filt_next;
			scan_end_s2 <= last_slot;
		end
	end

	assign out_valid = valid_s2;
	assign digit_select = digit_select_s2;
	assign segments = segments_s2;
	assign short_on = short_on_s2;
	assign stable_reading = stable_reading_s2;
	assign scan_end = scan_end_s2;

	// At most one digit is driven at a time
	a_select_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(digit_select))
		else $error("digit_select drives more than one digit");

	// Input is held off only when both registers are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free register");

	// The reading changes only on the last slot of a scan
	a_reading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && !last_slot) |=> (stable_reading == $past(filt_cur)))
		else $error("reading changed outside the last slot");

	// Short pulses are only flagged while dimming
	a_short_dim: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && !cfg_q.dim_enable) |=> !short_on)
		else $error("short_on set with dimming off");

endmodule

`default_nettype wire

// ----- rtl/core/s7s_digit.sv -----
`default_nettype none

module s7s_digit import s7s_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	localparam int SLOT_W = $clog2(DIGIT_COUNT)
) (
	input wire logic [SLOT_W-1:0] slot,
	input wire logic [VALUE_W-1:0] show_value,
	input wire logic [VALUE_W-1:0] remaining,
	input wire cfg_t cfg,
	output logic [DIGIT_COUNT-1:0] digit_select,
	output logic [7:0] segments,
	output logic short_on,
	output logic [VALUE_W-1:0] remaining_next
);

	logic first_slot;
	logic [VALUE_W-1:0] value;
	logic [DIV10_PROD_W-1:0] prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] quot_x10;
	logic [VALUE_W-1:0] rem_full;
	logic [3:0] rem;
	logic [3:0] slot_pos;
	logic blank;

	// Latch the new value on the first slot of a scan
	assign first_slot = (slot == '0);
	assign value = first_slot ? show_value : remaining;

	// Split off the low decimal digit by reciprocal multiply
	assign prod = DIV10_PROD_W'(value) * DIV10_PROD_W'(DIV10_MUL);
	assign quot = VALUE_W'(prod[DIV10_PROD_W-1:DIV10_SHIFT]);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem_full = value - quot_x10;
	assign rem = rem_full[3:0];
	assign remaining_next = quot;

	// One-based position of this slot
	assign slot_pos = 4'(slot) + 4'd1;

	// Drive active-low segments, clear the dot bit on the chosen digit
	always_comb begin
		segments = ~seg_pattern(rem);
		if ({1'b0, cfg.dot_position} == slot_pos) begin
			segments[7] = 1'b0;
		end
	end

	// Blank leading zeros when not dimming, flag short pulses when dimming
	assign blank = !cfg.dim_enable && (value == '0) && !first_slot;
	assign short_on = cfg.dim_enable && ({1'b0, cfg.bright_digit} != slot_pos);
	assign digit_select = blank ? '0 : (DIGIT_COUNT'(1) << slot);

endmodule

`default_nettype wire

// ----- rtl/core/s7s_filter.sv -----
`default_nettype none

module s7s_filter import s7s_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	parameter int SAMPLE_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire logic first_slot,
	input wire logic last_slot,
	input wire logic adc_enable,
	input wire logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] filtered_cur,
	output logic [SAMPLE_BITS-1:0] filtered_next
);

	localparam int DIVISOR = DIGIT_COUNT - 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(DIGIT_COUNT);
	localparam int DIV_SH = SUM_W + $clog2(DIVISOR);
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam int CMP_W = SAMPLE_BITS + 1;

	logic [SUM_W-1:0] sum_q;
	logic [SAMPLE_BITS-1:0] filt_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [COUNT_W-1:0] count_q;

	logic [SUM_W-1:0] sum_base;
	logic [SUM_W-1:0] sum_d;
	logic [PROD_W-1:0] prod;
	logic [SAMPLE_BITS-1:0] mean;
	logic [CMP_W-1:0] mean_x;
	logic [CMP_W-1:0] filt_x;
	logic far;
	logic [COUNT_W-1:0] count_inc;
	logic update;
	logic [SAMPLE_BITS-1:0] filt_d;
	logic [SAMPLE_BITS-1:0] prev_d;
	logic [COUNT_W-1:0] count_d;

	// Restart the sum on the first slot, add a sample on all but the last if enabled
	assign sum_base = first_slot ? '0 : sum_q;
	assign sum_d = (adc_enable && !last_slot) ? sum_base + SUM_W'(sample) : sum_base;

	// Truncated mean by reciprocal multiply, exact over the whole sum range
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign mean = prod[DIV_SH +: SAMPLE_BITS];

	// Decide whether the mean is far from the current reading
	assign mean_x = CMP_W'(mean);
	assign filt_x = CMP_W'(filt_q);
	assign far = ((filt_x >= CMP_W'(NEAR_BAND)) && (mean_x < filt_x - CMP_W'(NEAR_BAND)))
		|| (mean_x > filt_x + CMP_W'(NEAR_BAND));
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign update = adc_enable && last_slot;

	// Replace at once when far, else after enough repeats of the same mean
	always_comb begin
		filt_d = filt_q;
		prev_d = prev_q;
		count_d = count_q;
		if (update) begin
			if (far) begin
				filt_d = mean;
			end else if (prev_q == mean) begin
				count_d = count_inc;
				if (count_inc >= REPEAT_LIMIT) begin
					filt_d = mean;
				end
			end else begin
				prev_d = mean;
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			filt_q <= '0;
			prev_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			sum_q <= sum_d;
			filt_q <= filt_d;
			prev_q <= prev_d;
			count_q <= count_d;
		end
	end

	assign filtered_cur = filt_q;
	assign filtered_next = filt_d;

endmodule

`default_nettype wire
